// File: rtl/dis_pkg.sv
// Shared types, constants and the decay root table of the damped statistics block
package dis_pkg;

   localparam int LAMBDA_COUNT = 5;
   localparam int CSR_ADDR_W   = 5;

   typedef enum logic [2:0] {
      REG_LAMBDA0 = 3'd0,
      REG_LAMBDA1 = 3'd1,
      REG_LAMBDA2 = 3'd2,
      REG_LAMBDA3 = 3'd3,
      REG_LAMBDA4 = 3'd4,
      REG_MODE    = 3'd5
   } reg_idx_type;

   localparam logic [23:0] LAMBDA_RESET [LAMBDA_COUNT] = '{
      24'd327680, 24'd196608, 24'd65536, 24'd6554, 24'd655
   };

   // one queued item: the sample after interarrival substitution and the time step
   typedef struct packed {
      logic signed [31:0] sv;
      logic [47:0]        dt;
   } item_type;

   // request to the shared divider
   typedef struct packed {
      logic        start;
      logic [63:0] num;
      logic [47:0] den;
   } div_req_type;

   localparam logic [62:0] WIDE_CAP     = {63{1'b1}};
   localparam logic [47:0] WEIGHT_MAX   = {48{1'b1}};
   localparam logic [79:0] MEAN_POS_CAP = 80'h7FFF_FFFF_FFFF;
   localparam logic [79:0] MEAN_NEG_CAP = 80'h8000_0000_0000;

   // round(2^32 * 2^(-2^-(k+1))), k = 0..15
   function automatic logic [31:0] root_const(input logic [3:0] k);
      logic [31:0] c;
      unique case (k)
         4'd0:  c = 32'd3037000500;
         4'd1:  c = 32'd3611622603;
         4'd2:  c = 32'd3938502376;
         4'd3:  c = 32'd4112874773;
         4'd4:  c = 32'd4202935003;
         4'd5:  c = 32'd4248701965;
         4'd6:  c = 32'd4271771996;
         4'd7:  c = 32'd4283353945;
         4'd8:  c = 32'd4289156690;
         4'd9:  c = 32'd4292061010;
         4'd10: c = 32'd4293513907;
         4'd11: c = 32'd4294240540;
         4'd12: c = 32'd4294603903;
         4'd13: c = 32'd4294785595;
         4'd14: c = 32'd4294876445;
         default: c = 32'd4294921870;
      endcase
      return c;
   endfunction

endpackage

// File: rtl/dis_front.sv
// Front end: accepts samples, tracks the reference time and forms the time step
module dis_front
   import dis_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] sample_value,
   input  logic [47:0]        sample_time,
   input  logic               interarrival_mode,
   output logic               push_valid,
   input  logic               push_ready,
   output item_type           push_item
);

   logic [47:0] prev_time_ff, prev_time_in;
   logic        started_ff, started_in;
   logic [47:0] ref_time;
   logic [47:0] dt;
   logic        transfer;

   assign ref_time   = started_ff ? prev_time_ff : sample_time;
   assign dt         = (sample_time > ref_time) ? sample_time - ref_time : 48'd0;
   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign transfer   = req_valid && push_ready;

   always_comb begin
      push_item.dt = dt;
      if (interarrival_mode) begin
         push_item.sv = (dt[47:31] != 17'd0) ? 32'sh7FFF_FFFF : $signed({1'b0, dt[30:0]});
      end else begin
         push_item.sv = sample_value;
      end
   end

   always_comb begin
      prev_time_in = prev_time_ff;
      started_in   = started_ff;
      if (transfer) begin
         started_in = 1'b1;
         // take the first sample's time, then keep the reference time unless time moved forward
         if (!started_ff || dt != 48'd0) begin
            prev_time_in = sample_time;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_time_ff <= 48'd0;
         started_ff   <= 1'b0;
      end else begin
         prev_time_ff <= prev_time_in;
         started_ff   <= started_in;
      end
   end

endmodule

// File: rtl/dis_queue.sv
// Two-entry queue between the front end and the statistics engine
module dis_queue
   import dis_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop,
   output item_type pop_item
);

   item_type    mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/dis_div.sv
// Restoring divider, one quotient bit per cycle: floor(num * 2^16 / den)
module dis_div
   import dis_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output logic        busy,
   output logic [79:0] quot
);

   logic [79:0] d_ff, d_in;
   logic [47:0] rem_ff, rem_in;
   logic [47:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [48:0] trial;
   logic        qbit;

   assign busy  = busy_ff;
   assign quot  = d_ff;
   assign trial = {rem_ff, d_ff[79]};
   assign qbit  = (trial >= {1'b0, den_ff});

   always_comb begin
      d_in    = d_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (req.start) begin
         d_in    = {req.num, 16'd0};
         rem_in  = 48'd0;
         den_in  = req.den;
         cnt_in  = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = qbit ? 48'(trial - {1'b0, den_ff}) : trial[47:0];
         d_in   = {d_ff[78:0], qbit};
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd79) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      d_ff   <= d_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

endmodule

// File: rtl/dis_back.sv
// Statistics engine: decays and updates the window accumulators and forms each result
module dis_back
   import dis_pkg::*;
#(
   parameter int WINDOWS = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [23:0]        lambda [LAMBDA_COUNT],
   input  logic               item_valid,
   output logic               item_pop,
   input  item_type           item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         window_index,
   output logic [47:0]        decayed_weight,
   output logic signed [47:0] window_mean,
   output logic [62:0]        window_variance,
   output logic               last_window
);

   localparam int WIN_BITS = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
   localparam logic [WIN_BITS-1:0] WIN_LAST = WIN_BITS'(WINDOWS - 1);

   typedef enum logic [9:0] {
      ST_IDLE = 10'b00_0000_0001,
      ST_SQR  = 10'b00_0000_0010,
      ST_LAM  = 10'b00_0000_0100,
      ST_EXP  = 10'b00_0000_1000,
      ST_APL  = 10'b00_0001_0000,
      ST_ADD  = 10'b00_0010_0000,
      ST_DVM  = 10'b00_0100_0000,
      ST_SQM  = 10'b00_1000_0000,
      ST_DVV  = 10'b01_0000_0000,
      ST_EMIT = 10'b10_0000_0000
   } state_type;

   state_type           state_ff, state_in;
   logic [4:0]          step_ff, step_in;
   logic [WIN_BITS-1:0] win_ff, win_in;
   logic [1:0]          j_ff, j_in;
   logic signed [31:0]  sv_ff, sv_in;
   logic [47:0]         dt_ff, dt_in;
   logic [47:0]         vsq_ff, vsq_in;
   logic [15:0]         fb_ff, fb_in;
   logic [5:0]          n_ff, n_in;
   logic                zero_ff, zero_in;
   logic [32:0]         m_ff, m_in;
   logic [63:0]         res_ff, res_in;
   logic                neg_ff, neg_in;
   logic [47:0]         w_ff, w_in;
   logic [47:0]         mmag_ff, mmag_in;
   logic                big_ff, big_in;
   logic [79:0]         acc_ff, acc_in;
   logic [62:0]         var_ff, var_in;
   logic [63:0]         prod_ff;

   logic signed [63:0]  lin_ff [WINDOWS];
   logic [63:0]         sq_ff [WINDOWS];
   logic [47:0]         wt_ff [WINDOWS];
   logic                lin_we, sq_we, wt_we;
   logic signed [63:0]  lin_wd;
   logic [63:0]         sq_wd;
   logic [47:0]         wt_wd;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          idx_ff, idx_in;
   logic [47:0]         wgt_ff, wgt_in;
   logic signed [47:0]  mean_ff, mean_in;
   logic [62:0]         var_out_ff, var_out_in;
   logic                last_ff, last_in;

   logic [31:0]         mul_a, mul_b;
   div_req_type         div_req;
   logic                div_busy;
   logic [79:0]         div_quot;

   logic signed [63:0]  cur_lin;
   logic [63:0]         cur_sq;
   logic [47:0]         cur_wt;
   logic [63:0]         lin_mag;
   logic [31:0]         sv_mag;
   logic [32:0]         fac;
   logic [23:0]         lam_cur;
   logic [3:0]          k;
   logic [31:0]         root_k;
   logic [63:0]         rnd;
   logic [48:0]         p_sum;
   logic [63:0]         a_src;
   logic [63:0]         r_apl;
   logic signed [64:0]  lin_sum;
   logic signed [63:0]  lin_new;
   logic [64:0]         sq_sum;
   logic [63:0]         sq_new;
   logic [48:0]         wt_sum;
   logic [47:0]         wt_new;
   logic [79:0]         mean_cap;
   logic [47:0]         mmag_new;
   logic [62:0]         a_var, b_var;
   logic                win_is_last;

   assign cur_lin     = lin_ff[win_ff];
   assign cur_sq      = sq_ff[win_ff];
   assign cur_wt      = wt_ff[win_ff];
   assign lin_mag     = cur_lin[63] ? 64'(-cur_lin) : 64'(cur_lin);
   assign sv_mag      = sv_ff[31] ? 32'(-sv_ff) : 32'(sv_ff);
   assign fac         = zero_ff ? 33'd0 : (m_ff >> n_ff);
   assign lam_cur     = lambda[3'(win_ff)];
   assign k           = step_ff[4:1];
   assign root_k      = root_const(k);
   assign rnd         = prod_ff + 64'h8000_0000;
   assign p_sum       = {11'd0, res_ff[13:0], 24'd0} + {1'b0, prod_ff[47:0]};
   assign r_apl       = res_ff + {32'd0, prod_ff[63:32]};
   assign win_is_last = (win_ff == WIN_LAST);

   always_comb begin
      unique case (j_ff)
         2'd0:    a_src = lin_mag;
         2'd1:    a_src = cur_sq;
         default: a_src = {16'd0, cur_wt};
      endcase
   end

   // saturating sample update of the current window
   always_comb begin
      lin_sum = {cur_lin[63], cur_lin} + 65'(sv_ff);
      if (!lin_sum[64] && lin_sum[63]) begin
         lin_new = 64'sh7FFF_FFFF_FFFF_FFFF;
      end else if (lin_sum[64] && (!lin_sum[63] || lin_sum[62:0] == 63'd0)) begin
         lin_new = -64'sh7FFF_FFFF_FFFF_FFFF;
      end else begin
         lin_new = lin_sum[63:0];
      end
      sq_sum = {1'b0, cur_sq} + {17'd0, vsq_ff};
      sq_new = sq_sum[64] ? {64{1'b1}} : sq_sum[63:0];
      wt_sum = {1'b0, cur_wt} + 49'h1_0000;
      wt_new = wt_sum[48] ? WEIGHT_MAX : wt_sum[47:0];
   end

   assign mean_cap = neg_ff ? MEAN_NEG_CAP : MEAN_POS_CAP;
   assign mmag_new = (div_quot > mean_cap) ? mean_cap[47:0] : div_quot[47:0];

   always_comb begin
      a_var = (div_quot > {17'd0, WIDE_CAP}) ? WIDE_CAP : div_quot[62:0];
      if (big_ff || acc_ff[79]) begin
         b_var = WIDE_CAP;
      end else begin
         b_var = acc_ff[78:16];
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      win_in       = win_ff;
      j_in         = j_ff;
      sv_in        = sv_ff;
      dt_in        = dt_ff;
      vsq_in       = vsq_ff;
      fb_in        = fb_ff;
      n_in         = n_ff;
      zero_in      = zero_ff;
      m_in         = m_ff;
      res_in       = res_ff;
      neg_in       = neg_ff;
      w_in         = w_ff;
      mmag_in      = mmag_ff;
      big_in       = big_ff;
      acc_in       = acc_ff;
      var_in       = var_ff;
      lin_we       = 1'b0;
      sq_we        = 1'b0;
      wt_we        = 1'b0;
      lin_wd       = lin_new;
      sq_wd        = sq_new;
      wt_wd        = wt_new;
      mul_a        = 32'd0;
      mul_b        = 32'd0;
      div_req      = '0;
      item_pop     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      idx_in       = idx_ff;
      wgt_in       = wgt_ff;
      mean_in      = mean_ff;
      var_out_in   = var_out_ff;
      last_in      = last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               sv_in    = item.sv;
               dt_in    = item.dt;
               win_in   = '0;
               step_in  = 5'd0;
               state_in = ST_SQR;
            end
         end
         ST_SQR: begin
            mul_a = sv_mag;
            mul_b = sv_mag;
            if (step_ff == 5'd0) begin
               step_in = 5'd1;
            end else begin
               vsq_in   = prod_ff[63:16];
               step_in  = 5'd0;
               state_in = (dt_ff != 48'd0) ? ST_LAM : ST_ADD;
            end
         end
         ST_LAM: begin
            mul_a = {8'd0, lam_cur};
            if (step_ff == 5'd0) begin
               mul_b   = {8'd0, dt_ff[47:24]};
               step_in = 5'd1;
            end else if (step_ff == 5'd1) begin
               res_in  = prod_ff;
               mul_b   = {8'd0, dt_ff[23:0]};
               step_in = 5'd2;
            end else begin
               // whole part of 33 or more leaves nothing of the accumulators
               zero_in  = (res_ff[47:14] != 34'd0) || (p_sum[48:32] >= 17'd33);
               n_in     = p_sum[37:32];
               fb_in    = p_sum[31:16];
               m_in     = 33'h1_0000_0000;
               step_in  = 5'd0;
               state_in = ST_EXP;
            end
         end
         ST_EXP: begin
            mul_a = m_ff[31:0];
            mul_b = root_k;
            if (step_ff[0] && fb_ff[~k]) begin
               m_in = m_ff[32] ? {1'b0, root_k} : {1'b0, rnd[63:32]};
            end
            if (step_ff == 5'd31) begin
               step_in  = 5'd0;
               j_in     = 2'd0;
               state_in = ST_APL;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
         ST_APL: begin
            mul_b = fac[31:0];
            if (fac[32] || (step_ff == 5'd2 && j_ff == 2'd2)) begin
               if (!fac[32]) begin
                  wt_we = 1'b1;
                  wt_wd = (r_apl[47:0] == 48'd0) ? 48'd1 : r_apl[47:0];
               end
               step_in = 5'd0;
               j_in    = 2'd0;
               if (win_is_last) begin
                  win_in   = '0;
                  state_in = ST_ADD;
               end else begin
                  win_in   = win_ff + WIN_BITS'(1);
                  state_in = ST_LAM;
               end
            end else if (step_ff == 5'd0) begin
               mul_a   = a_src[63:32];
               step_in = 5'd1;
            end else if (step_ff == 5'd1) begin
               res_in  = prod_ff;
               mul_a   = a_src[31:0];
               step_in = 5'd2;
            end else begin
               if (j_ff == 2'd0) begin
                  lin_we = 1'b1;
                  lin_wd = cur_lin[63] ? -$signed(r_apl) : $signed(r_apl);
               end else begin
                  sq_we = 1'b1;
                  sq_wd = r_apl;
               end
               j_in    = j_ff + 2'd1;
               step_in = 5'd0;
            end
         end
         ST_ADD: begin
            lin_we        = 1'b1;
            sq_we         = 1'b1;
            wt_we         = 1'b1;
            neg_in        = lin_new[63];
            w_in          = wt_new;
            div_req.start = 1'b1;
            div_req.num   = lin_new[63] ? 64'(-lin_new) : 64'(lin_new);
            div_req.den   = wt_new;
            state_in      = ST_DVM;
         end
         ST_DVM: begin
            if (!div_busy) begin
               mmag_in       = mmag_new;
               big_in        = (mmag_new[47:40] != 8'd0);
               div_req.start = 1'b1;
               div_req.num   = cur_sq;
               div_req.den   = w_ff;
               step_in       = 5'd0;
               state_in      = ST_SQM;
            end
         end
         ST_SQM: begin
            // mean squared from 32-bit partial products while the divider runs
            if (step_ff == 5'd0) begin
               mul_a   = mmag_ff[31:0];
               mul_b   = mmag_ff[31:0];
               step_in = 5'd1;
            end else if (step_ff == 5'd1) begin
               acc_in  = {16'd0, prod_ff};
               mul_a   = {24'd0, mmag_ff[39:32]};
               mul_b   = mmag_ff[31:0];
               step_in = 5'd2;
            end else if (step_ff == 5'd2) begin
               acc_in  = acc_ff + (80'(prod_ff) << 33);
               mul_a   = {24'd0, mmag_ff[39:32]};
               mul_b   = {24'd0, mmag_ff[39:32]};
               step_in = 5'd3;
            end else begin
               acc_in   = acc_ff + (80'(prod_ff) << 64);
               step_in  = 5'd0;
               state_in = ST_DVV;
            end
         end
         ST_DVV: begin
            if (!div_busy) begin
               var_in   = (a_var >= b_var) ? a_var - b_var : b_var - a_var;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               idx_in       = 3'(win_ff);
               wgt_in       = w_ff;
               mean_in      = neg_ff ? -$signed(mmag_ff) : $signed(mmag_ff);
               var_out_in   = var_ff;
               last_in      = win_is_last;
               if (win_is_last) begin
                  win_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  win_in   = win_ff + WIN_BITS'(1);
                  state_in = ST_ADD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   dis_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .busy  (div_busy),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      prod_ff    <= mul_a * mul_b;
      sv_ff      <= sv_in;
      dt_ff      <= dt_in;
      vsq_ff     <= vsq_in;
      fb_ff      <= fb_in;
      n_ff       <= n_in;
      zero_ff    <= zero_in;
      m_ff       <= m_in;
      res_ff     <= res_in;
      neg_ff     <= neg_in;
      w_ff       <= w_in;
      mmag_ff    <= mmag_in;
      big_ff     <= big_in;
      acc_ff     <= acc_in;
      var_ff     <= var_in;
      idx_ff     <= idx_in;
      wgt_ff     <= wgt_in;
      mean_ff    <= mean_in;
      var_out_ff <= var_out_in;
      last_ff    <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOWS; i++) begin
            lin_ff[i] <= '0;
            sq_ff[i]  <= '0;
            wt_ff[i]  <= 48'd1;
         end
      end else begin
         if (lin_we) begin
            lin_ff[win_ff] <= lin_wd;
         end
         if (sq_we) begin
            sq_ff[win_ff] <= sq_wd;
         end
         if (wt_we) begin
            wt_ff[win_ff] <= wt_wd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= 5'd0;
         win_ff       <= '0;
         j_ff         <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         win_ff       <= win_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign window_index    = idx_ff;
   assign decayed_weight  = wgt_ff;
   assign window_mean     = mean_ff;
   assign window_variance = var_out_ff;
   assign last_window     = last_ff;

endmodule

// File: rtl/damped_incremental_statistics_top.sv
// Damped incremental statistics: control registers, front end, queue and engine
//
// Each accepted sample updates WINDOWS exponentially decayed windows and yields one
// result per window, in window order, the last one flagged. When its timestamp
// advances, each window also takes the lambda products and a 16-step root product
// on one 32x32 multiplier. The shared divider, which delivers one quotient bit per
// cycle, forms each mean and each variance. A two-entry queue takes further
// samples while the engine works, and a finished result waits in the output
// register without holding up the next window.
module damped_incremental_statistics_top
   import dis_pkg::*;
#(
   parameter int WINDOWS = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic signed [31:0]    req_sample_value,
   input  logic [47:0]           req_sample_time,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            rsp_window_index,
   output logic [47:0]           rsp_decayed_weight,
   output logic signed [47:0]    rsp_window_mean,
   output logic [62:0]           rsp_window_variance,
   output logic                  rsp_last_window,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic [23:0] lambda_ff [LAMBDA_COUNT];
   logic        mode_ff;
   logic        csr_wr;
   reg_idx_type csr_idx;

   logic        push_valid, push_ready;
   item_type    push_item;
   logic        q_valid, q_pop;
   item_type    q_item;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = reg_idx_type'(paddr[4:2]);

   always_comb begin
      unique case (csr_idx)
         REG_LAMBDA0: prdata = {8'd0, lambda_ff[0]};
         REG_LAMBDA1: prdata = {8'd0, lambda_ff[1]};
         REG_LAMBDA2: prdata = {8'd0, lambda_ff[2]};
         REG_LAMBDA3: prdata = {8'd0, lambda_ff[3]};
         REG_LAMBDA4: prdata = {8'd0, lambda_ff[4]};
         REG_MODE:    prdata = {31'd0, mode_ff};
         default:     prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAMBDA_COUNT; i++) begin
            lambda_ff[i] <= LAMBDA_RESET[i];
         end
         mode_ff <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_LAMBDA0: lambda_ff[0] <= pwdata[23:0];
            REG_LAMBDA1: lambda_ff[1] <= pwdata[23:0];
            REG_LAMBDA2: lambda_ff[2] <= pwdata[23:0];
            REG_LAMBDA3: lambda_ff[3] <= pwdata[23:0];
            REG_LAMBDA4: lambda_ff[4] <= pwdata[23:0];
            REG_MODE:    mode_ff <= pwdata[0];
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   dis_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .sample_value      (req_sample_value),
      .sample_time       (req_sample_time),
      .interarrival_mode (mode_ff),
      .push_valid        (push_valid),
      .push_ready        (push_ready),
      .push_item         (push_item)
   );

   dis_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_item   (q_item)
   );

   dis_back #(
      .WINDOWS (WINDOWS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .lambda          (lambda_ff),
      .item_valid      (q_valid),
      .item_pop        (q_pop),
      .item            (q_item),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .window_index    (rsp_window_index),
      .decayed_weight  (rsp_decayed_weight),
      .window_mean     (rsp_window_mean),
      .window_variance (rsp_window_variance),
      .last_window     (rsp_last_window)
   );

endmodule
